// ===== src/pcf_payload_bit_framer_core_macros.svh =====
// Assertion macros shared by the framer RTL.
// Depends on nothing; files that assert include it by its bare name.
`ifndef PCF_PAYLOAD_BIT_FRAMER_CORE_MACROS_SVH
`define PCF_PAYLOAD_BIT_FRAMER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define PCF_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("framer check failed");

// Next-cycle implication, disabled while reset is held.
`define PCF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("framer check failed");

`endif

// ===== src/pcf_pkg.sv =====
// Shared types and constants of the payload bit framer.
// Used by pcf_framer, pcf_out_buf and the top level.
package pcf_pkg;

  localparam int BYTE_W      = 8;
  localparam int LEN_W       = 6;
  localparam int ID_W        = 2;
  localparam int IN_TDATA_W  = 16;
  localparam int MAX_RESULTS = 3;
  localparam int CNT_W       = 2;
  localparam int IDX_W       = 2;

  // Up to three framed bytes caused by one payload word.
  typedef struct packed {
    logic                                valid;
    logic [CNT_W-1:0]                    cnt;
    logic                                last;
    logic [MAX_RESULTS-1:0][BYTE_W-1:0]  bytes;
  } bundle_t;

endpackage

// ===== src/pcf_framer.sv =====
// Input register, packet state and the combinational framing of one word.
// Depends on pcf_pkg and the assertion macro header.
`include "pcf_payload_bit_framer_core_macros.svh"

module pcf_framer
  import pcf_pkg::*;
#(
  parameter int MAX_PAYLOAD = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_TDATA_W-1:0] s_tdata,
  input  logic                  no_ack,
  input  logic                  buf_free,
  output bundle_t               bnd
);

  localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MAX_PAYLOAD);

  logic              item_valid;
  logic [BYTE_W-1:0] item_data;
  logic [LEN_W-1:0]  item_len;

  logic              in_packet, in_packet_next;
  logic              carry_bit, carry_bit_next;
  logic [LEN_W-1:0]  bytes_left, bytes_left_next;
  logic [ID_W-1:0]   packet_id, packet_id_next;

  logic              take;
  logic [LEN_W-1:0]  len_clamped;

  assign take     = item_valid && buf_free;
  assign s_tready = !item_valid || buf_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      item_valid <= 1'b1;
    end else if (take) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item_data <= s_tdata[BYTE_W-1:0];
      item_len  <= s_tdata[BYTE_W +: LEN_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_packet  <= 1'b0;
      carry_bit  <= 1'b0;
      bytes_left <= '0;
      packet_id  <= '0;
    end else if (take) begin
      in_packet  <= in_packet_next;
      carry_bit  <= carry_bit_next;
      bytes_left <= bytes_left_next;
      packet_id  <= packet_id_next;
    end
  end

  assign len_clamped = (item_len > MaxLen) ? MaxLen : item_len;

  always_comb begin
    in_packet_next  = in_packet;
    carry_bit_next  = carry_bit;
    bytes_left_next = bytes_left;
    packet_id_next  = packet_id;
    bnd.valid       = item_valid;
    bnd.cnt         = CNT_W'(1);
    bnd.last        = 1'b0;
    bnd.bytes       = '0;

    if (!in_packet) begin
      // Control byte: length in the low six bits, packet id on top.
      bnd.bytes[0] = {packet_id, len_clamped};
      if (len_clamped == '0) begin
        // Empty packet: control byte and a lone no-ack byte.
        bnd.bytes[1]    = {{(BYTE_W-1){1'b0}}, no_ack};
        bnd.cnt         = CNT_W'(2);
        bnd.last        = 1'b1;
        packet_id_next  = packet_id + ID_W'(1);
        bytes_left_next = '0;
      end else begin
        bnd.bytes[1]    = {item_data[BYTE_W-2:0], no_ack};
        carry_bit_next  = item_data[BYTE_W-1];
        bytes_left_next = len_clamped - LEN_W'(1);
        if (bytes_left_next == '0) begin
          bnd.bytes[2]   = {{(BYTE_W-1){1'b0}}, item_data[BYTE_W-1]};
          bnd.cnt        = CNT_W'(3);
          bnd.last       = 1'b1;
          packet_id_next = packet_id + ID_W'(1);
        end else begin
          bnd.cnt        = CNT_W'(2);
          in_packet_next = 1'b1;
        end
      end
    end else begin
      bnd.bytes[0]    = {item_data[BYTE_W-2:0], carry_bit};
      carry_bit_next  = item_data[BYTE_W-1];
      bytes_left_next = bytes_left - LEN_W'(1);
      if (bytes_left_next == '0) begin
        // Final byte carries only the top bit of the last payload byte.
        bnd.bytes[1]   = {{(BYTE_W-1){1'b0}}, item_data[BYTE_W-1]};
        bnd.cnt        = CNT_W'(2);
        bnd.last       = 1'b1;
        packet_id_next = packet_id + ID_W'(1);
        in_packet_next = 1'b0;
      end
    end
  end

  `PCF_ASSERT_NOW(a_left_nonzero, clk, rst, in_packet, bytes_left != '0)
  `PCF_ASSERT_NOW(a_three_only_first, clk, rst, item_valid && bnd.cnt == CNT_W'(3), !in_packet)
  `PCF_ASSERT_NEXT(a_last_ends_packet, clk, rst, take && bnd.last, !in_packet)

endmodule

// ===== src/pcf_out_buf.sv =====
// Result register holding up to three framed bytes, drained one per cycle while m_tready is high.
// Depends on pcf_pkg.
module pcf_out_buf
  import pcf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  bundle_t           bnd,
  output logic              buf_free,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [BYTE_W-1:0] m_tdata,
  output logic              m_tlast
);

  logic [CNT_W-1:0]                   rem;
  logic [IDX_W-1:0]                   idx;
  logic                               last_flag;
  logic [MAX_RESULTS-1:0][BYTE_W-1:0] bytes_r;

  assign buf_free = (rem == '0) || ((rem == CNT_W'(1)) && m_tready);
  assign m_tvalid = (rem != '0);
  assign m_tdata  = bytes_r[idx];
  assign m_tlast  = last_flag && (rem == CNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
      idx <= '0;
    end else if (bnd.valid && buf_free) begin
      rem <= bnd.cnt;
      idx <= '0;
    end else if (m_tvalid && m_tready) begin
      rem <= rem - CNT_W'(1);
      idx <= idx + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (bnd.valid && buf_free) begin
      bytes_r   <= bnd.bytes;
      last_flag <= bnd.last;
    end
  end

endmodule

// ===== src/pcf_payload_bit_framer_core.sv =====
// Top level of the payload bit framer: no-ack register and the two stages.
// Depends on pcf_pkg, pcf_framer and pcf_out_buf.
//
//   channel  | direction | signals                          | word
//   ---------+-----------+----------------------------------+-------------------------
//   s_*      | in        | s_tvalid s_tready s_tdata        | payload byte + length
//   m_*      | out       | m_tvalid m_tready m_tdata m_tlast| one framed byte
//   cfg_*    | in        | cfg_valid cfg_ready cfg_data     | no-ack flag
//
// A payload word that produces one framed byte is taken every cycle while the
// output side keeps up. The first word of a packet produces two or three bytes
// and the last payload word two, so these hold the output port until all their bytes
// have left; the output port's one byte per cycle sets the rate.
// The first framed byte of a word passes the input register, then the result register.
// Reset is synchronous and clears the packet state, packet id and no-ack flag.
// A stall on the output holds the result register, and the input register
// then fills and drops s_tready.
module pcf_payload_bit_framer_core
  import pcf_pkg::*;
#(
  parameter int MAX_PAYLOAD = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_TDATA_W-1:0] s_tdata,   // [7:0] data_byte, [13:8] length, [15:14] zero
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [BYTE_W-1:0]     m_tdata,   // [7:0] frame_byte
  output logic                  m_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_data
);

  // The no-ack flag is sampled by the framer when a packet's first word is
  // framed; the user must write it only while idle; the block does not enforce this.
  logic    no_ack_flag;
  bundle_t bnd;
  logic    buf_free;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      no_ack_flag <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      no_ack_flag <= cfg_data;
    end
  end

  // Input register and the framing logic for one word.
  pcf_framer #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_framer (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .no_ack   (no_ack_flag),
    .buf_free (buf_free),
    .bnd      (bnd)
  );

  // Result register; it takes a new bundle as its last byte leaves, so
  // single-byte words stream without a bubble.
  pcf_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .bnd      (bnd),
    .buf_free (buf_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

// ===== tb/tb_pcf_payload_bit_framer_core.sv =====
// Self-checking testbench for the payload bit framer top level.
// Depends on pcf_pkg and pcf_payload_bit_framer_core; it predicts every framed word
// from its own model of the framing and compares the output stream word by word.
module tb_pcf_payload_bit_framer_core;
  import pcf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_LEN      = 32;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 120;
  localparam int RANDOM_WORDS = 60;
  localparam int REPORT_MAX   = 10;

  // Receiver behavior: always ready, ready at random (60 percent), or a fixed duty pattern.
  typedef enum logic [1:0] {RX_FREE, RX_RANDOM, RX_PERIODIC} rx_mode_e;

  // One expected framed word on the output.
  typedef struct {
    logic [BYTE_W-1:0] fbyte;
    logic              flast;
  } framed_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_TDATA_W-1:0] s_tdata = '0;   // [7:0] data_byte, [13:8] length, [15:14] zero
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [BYTE_W-1:0]     m_tdata;        // [7:0] frame_byte
  logic                  m_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic                  cfg_data = 1'b0;

  // Predictor state: a copy of the framer's packet state and its no-ack register.
  logic              pkt_open = 1'b0;
  logic              carry = 1'b0;
  logic [LEN_W-1:0]  remaining = '0;
  logic [ID_W-1:0]   pkt_id = '0;
  logic              no_ack = 1'b0;
  framed_t           framed_exp[$];
  framed_t           want;

  // Run bookkeeping.
  int       cycle_cnt = 0;
  int       words_sent = 0;
  int       packets_sent = 0;
  int       bytes_checked = 0;
  int       mismatches = 0;
  int       burst_left = 0;
  bit       tx_gaps = 1'b0;
  rx_mode_e rx_mode = RX_FREE;
  int       rx_tick = 0;
  logic     rx_open;
  logic     hold_start = 1'b0;
  int       hold_left = 0;

  pcf_payload_bit_framer_core #(
    .MAX_PAYLOAD(MAX_LEN)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // The watchdog ends a run that stops making progress.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected", cycle_cnt,
               framed_exp.size());
      $display("pcf_payload_bit_framer_core regression: fail");
      $finish;
    end
  end

  // Long receiver hold-off. A one-cycle pulse on hold_start loads the counter, and
  // the receiver stays stalled until it runs out.
  always @(posedge clk) begin
    if (hold_start) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  task automatic note_error(input string what);
    mismatches++;
    if (mismatches <= REPORT_MAX) begin
      $display("error at cycle %0d: %s", cycle_cnt, what);
    end
  endtask

  // Works out the framed words that one accepted payload word causes. The first
  // word of a packet emits the control byte (length and packet id) and then the
  // no-ack bit with the payload shifted up by one; later words emit the carried
  // top bit of the previous byte under the new byte. The word that completes the
  // payload also emits the final one-bit byte. A zero length closes the packet at
  // once with the control byte and a lone no-ack byte, and the data is dropped.
  task automatic predict_frame(input logic [BYTE_W-1:0] data, input logic [LEN_W-1:0] len_in);
    logic [LEN_W-1:0] len;
    logic             closing;
    len = len_in;
    closing = 1'b0;
    if (!pkt_open) begin
      if (len > MAX_LEN) begin
        len = LEN_W'(MAX_LEN);
      end
      framed_exp.push_back('{fbyte: {pkt_id, len}, flast: 1'b0});
      if (len == 0) begin
        framed_exp.push_back('{fbyte: {7'd0, no_ack}, flast: 1'b1});
        pkt_id = pkt_id + 1'b1;
      end else begin
        framed_exp.push_back('{fbyte: {data[6:0], no_ack}, flast: 1'b0});
        carry = data[7];
        remaining = len - 1'b1;
        pkt_open = 1'b1;
        closing = (remaining == 0);
      end
    end else begin
      framed_exp.push_back('{fbyte: {data[6:0], carry}, flast: 1'b0});
      carry = data[7];
      remaining = remaining - 1'b1;
      closing = (remaining == 0);
    end
    if (closing) begin
      framed_exp.push_back('{fbyte: {7'd0, carry}, flast: 1'b1});
      pkt_id = pkt_id + 1'b1;
      pkt_open = 1'b0;
      remaining = '0;
    end
  endtask

  // Output side: every accepted framed word is checked against the oldest
  // expectation, then the next ready level is chosen from the current stall mode.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (framed_exp.size() == 0) begin
        note_error($sformatf("unexpected word byte=%02h last=%0b", m_tdata, m_tlast));
      end else begin
        want = framed_exp.pop_front();
        bytes_checked++;
        if (m_tdata !== want.fbyte || m_tlast !== want.flast) begin
          note_error($sformatf("expected byte=%02h last=%0b, got byte=%02h last=%0b",
                               want.fbyte, want.flast, m_tdata, m_tlast));
        end
      end
    end
    rx_tick <= rx_tick + 1;
    case (rx_mode)
      RX_FREE:   rx_open = 1'b1;
      RX_RANDOM: rx_open = ($urandom_range(0, 99) < 60);
      default:   rx_open = ((rx_tick % 5) < 2);
    endcase
    m_tready <= rx_open && (hold_left == 0);
  end

  // Offers one payload word and returns at the edge where it is taken, or after the gap
  // that ends a burst. Otherwise valid stays high, so the next word needs no new edge.
  task automatic send_word(input logic [BYTE_W-1:0] data, input logic [LEN_W-1:0] len);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, len, data};
    do @(posedge clk); while (!s_tready);
    predict_frame(data, len);
    words_sent++;
    // Bursts of random length separated by random gaps, when gaps are enabled.
    if (tx_gaps) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 6);
        burst_left = $urandom_range(1, 8);
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Waits until every expected framed word has come out.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (framed_exp.size() != 0) @(posedge clk);
  endtask

  // Writes the no-ack register; only called while the framer is idle.
  task automatic write_no_ack(input logic value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    no_ack = value;
  endtask

  // Sends one whole packet with random payload; later words carry random
  // length fields, which the framer must ignore.
  task automatic send_random_packet(input logic [LEN_W-1:0] len);
    int count;
    count = (len == 0) ? 1 : ((len > MAX_LEN) ? MAX_LEN : len);
    send_word(BYTE_W'($urandom_range(0, 255)), len);
    for (int i = 1; i < count; i++) begin
      send_word(BYTE_W'($urandom_range(0, 255)), LEN_W'($urandom_range(0, 63)));
    end
    packets_sent++;
  endtask

  // Right after reset the no-ack bit must read zero and the packet id start at zero.
  task automatic test_reset_state();
    rx_mode = RX_FREE;
    tx_gaps = 1'b0;
    send_word(8'hFF, 6'd0);
    packets_sent++;
  endtask

  // Data extremes, the shortest packets, ignored lengths inside a packet, both
  // no-ack settings, and enough packets to wrap the packet id.
  task automatic test_directed();
    write_no_ack(1'b1);
    send_word(8'h00, 6'd0);
    send_word(8'hFF, 6'd1);
    send_word(8'h00, 6'd1);
    send_word(8'h80, 6'd2);
    send_word(8'h7F, 6'd63);
    send_word(8'h55, 6'd3);
    send_word(8'hAA, 6'd0);
    send_word(8'h01, 6'd1);
    packets_sent += 5;
    write_no_ack(1'b0);
    rx_mode = RX_PERIODIC;
    send_word(8'hA5, 6'd1);
    send_word(8'h3C, 6'd0);
    packets_sent += 2;
  endtask

  // The receiver holds off for a long stretch while a full-size packet (its
  // length field at the top of its range, so it is clamped) is offered without
  // gaps; the framer has to fill up and stop taking words.
  task automatic test_backpressure();
    write_no_ack(1'b1);
    rx_mode = RX_FREE;
    tx_gaps = 1'b0;
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    send_random_packet(6'd63);
  endtask

  // Random packets, mostly short, with a few zero-length and over-long ones.
  // Each phase picks the no-ack setting at random and changes the stall mode and the sender pacing.
  task automatic test_random();
    int start;
    int pick;
    logic [LEN_W-1:0] len;
    start = words_sent;
    for (int phase = 0; words_sent - start < RANDOM_WORDS; phase++) begin
      write_no_ack(1'($urandom_range(0, 1)));
      rx_mode = rx_mode_e'(phase % 3);
      tx_gaps = (phase % 2 == 0);
      for (int n = 0; n < 6 && words_sent - start < RANDOM_WORDS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
          len = 6'd0;
        end else if (pick < 80) begin
          len = LEN_W'($urandom_range(1, 6));
        end else if (pick < 96) begin
          len = LEN_W'($urandom_range(7, 20));
        end else begin
          len = LEN_W'($urandom_range(MAX_LEN, 63));
        end
        send_random_packet(len);
      end
    end
  endtask

  initial begin
    framed_t stale;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_directed();
    test_backpressure();
    test_random();

    rx_mode = RX_FREE;
    wait_drained();
    repeat (10) @(posedge clk);
    while (framed_exp.size() != 0) begin
      stale = framed_exp.pop_front();
      note_error($sformatf("missing word byte=%02h last=%0b", stale.fbyte, stale.flast));
    end

    $display("sent %0d payload words in %0d packets, checked %0d framed words",
             words_sent, packets_sent, bytes_checked);
    $display("covered both no-ack settings, clamped lengths, id wrap and a long output stall");
    if (mismatches == 0) begin
      $display("pcf_payload_bit_framer_core regression: pass");
    end else begin
      $display("%0d errors", mismatches);
      $display("pcf_payload_bit_framer_core regression: fail");
    end
    $finish;
  end

endmodule
